// ----- rtl/tsog_pkg.sv -----
// shared types and constants for the strided tensor offset generator
package tsog_pkg;

  localparam int CARRIED    = 4;
  localparam int IDX_W      = 32;
  localparam int OFS_W      = 63;
  localparam int SIZE_W     = 31;
  localparam int TERM_W     = 62;
  localparam int CFG_IDX_W  = 3;
  localparam int SEL_W      = 2;
  localparam int STRIDE_LSB = 32;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RANK     = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RANK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM0 = 3'd2;

  typedef struct packed {
    logic              active;
    logic              bad;
    logic [TERM_W-1:0] term;
  } lane_res_t;

  typedef struct packed {
    logic [OFS_W-1:0] acc;
    logic [1:0]       status;
    logic [SEL_W-1:0] edim;
  } acc_t;

endpackage

// ----- rtl/tsog_lane.sv -----
// one dimension lane: index selection, range check and stride product
module tsog_lane import tsog_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    func_i,
  input  logic [SEL_W-1:0]        shift_i,
  input  logic signed [IDX_W-1:0] idx_i [CARRIED],
  input  logic [OFS_W-1:0]        shape_i,
  input  logic                    active_i,
  output lane_res_t               res_o
);

  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] stride;
  logic [SEL_W-1:0]  sel;
  logic [IDX_W-1:0]  ix;
  lane_res_t         res_d;
  lane_res_t         res_q;

  always_comb begin
    size   = shape_i[SIZE_W-1:0];
    stride = shape_i[STRIDE_LSB +: SIZE_W];
    sel    = shift_i + SEL_W'(LANE);
    if (func_i && size == SIZE_W'(1)) begin
      ix = '0;
    end else begin
      ix = idx_i[sel];
    end
    res_d.active = active_i;
    res_d.bad    = ix[IDX_W-1] || (ix[SIZE_W-1:0] >= size);
    res_d.term   = TERM_W'(ix[SIZE_W-1:0]) * TERM_W'(stride);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/tsog_merge.sv -----
// merge step: folds one lane into the running offset and first-failure status
module tsog_merge import tsog_pkg::*; #(
  parameter int NLANE = 4,
  parameter int STEP  = 0
) (
  input  logic      clk_i,
  input  logic      en_i,
  input  acc_t      acc_i,
  input  lane_res_t lanes_i [NLANE],
  output acc_t      acc_o,
  output lane_res_t lanes_o [NLANE]
);

  logic [OFS_W:0] sum;
  acc_t           acc_d;
  acc_t           acc_q;
  lane_res_t      lanes_q [NLANE];

  always_comb begin
    acc_d = acc_i;
    sum   = {1'b0, acc_i.acc} + (OFS_W+1)'(lanes_i[STEP].term);
    if (acc_i.status == STATUS_OK && lanes_i[STEP].active) begin
      if (lanes_i[STEP].bad) begin
        acc_d.status = STATUS_RANGE;
        acc_d.edim   = SEL_W'(STEP);
      end else if (sum[OFS_W]) begin
        acc_d.status = STATUS_OVERFLOW;
        acc_d.edim   = SEL_W'(STEP);
      end else begin
        acc_d.acc = sum[OFS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q   <= acc_d;
      lanes_q <= lanes_i;
    end
  end

  assign acc_o   = acc_q;
  assign lanes_o = lanes_q;

endmodule

// ----- rtl/tensor_strided_offset_generator_top.sv -----
// top level of the strided tensor offset generator
//
//   channel   signals                                  role
//   in        in_valid_i / in_ready_o, func .. idx_3   index request
//   out       out_valid_o / out_ready_i, offset ..     offset, status, failing dim
//   cfg       cfg_we_i, cfg_idx_i, cfg_data_i          register write, no wait
//
// the pipeline is one lane stage, then one merge adder per dimension
// one request per cycle sustained while out_ready_i is high; each stage holds only while the one after it is full
// a stalled output fills the pipeline before in_ready_o drops
// reset clears the stage valids and the configuration registers
module tensor_strided_offset_generator_top import tsog_pkg::*; #(
  parameter int MAX_RANK = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [OFS_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    func_i,
  input  logic [2:0]              index_count_i,
  input  logic signed [IDX_W-1:0] idx_0_i,
  input  logic signed [IDX_W-1:0] idx_1_i,
  input  logic signed [IDX_W-1:0] idx_2_i,
  input  logic signed [IDX_W-1:0] idx_3_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OFS_W-1:0]        offset_o,
  output logic [1:0]              status_o,
  output logic [1:0]              error_dim_o
);

  localparam int LIMIT = (MAX_RANK < CARRIED) ? MAX_RANK : CARRIED;
  localparam int NSTG  = LIMIT + 1;

  logic [2:0]       rank_q;
  logic [OFS_W-1:0] base_q;
  logic [OFS_W-1:0] shape_q [LIMIT];

  logic [NSTG-1:0]  vld_q;
  logic [NSTG:0]    en;

  logic signed [IDX_W-1:0] idx [CARRIED];
  logic                    rank_bad;
  logic [2:0]              shift;
  acc_t                    hdr_d;
  acc_t                    hdr_q;

  acc_t      acc_s   [NSTG];
  lane_res_t lanes_s [NSTG][LIMIT];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= '0;
      base_q  <= '0;
      shape_q <= '{default: '0};
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_RANK) begin
        rank_q <= cfg_data_i[2:0];
      end
      if (cfg_idx_i == REG_BASE) begin
        base_q <= cfg_data_i;
      end
      for (int d = 0; d < LIMIT; d++) begin
        if (cfg_idx_i == REG_DIM0 + CFG_IDX_W'(d)) begin
          shape_q[d] <= cfg_data_i;
        end
      end
    end
  end

  // stall chain
  always_comb begin
    en[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // rank check and broadcast alignment
  always_comb begin
    idx[0]   = idx_0_i;
    idx[1]   = idx_1_i;
    idx[2]   = idx_2_i;
    idx[3]   = idx_3_i;
    rank_bad = (rank_q > 3'(LIMIT)) || (index_count_i > 3'(LIMIT)) ||
               (!func_i && index_count_i != rank_q) ||
               (func_i && rank_q > index_count_i);
    shift    = (func_i && !rank_bad) ? (index_count_i - rank_q) : 3'd0;
    hdr_d.acc    = base_q;
    hdr_d.status = rank_bad ? STATUS_RANK : STATUS_OK;
    hdr_d.edim   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hdr_q <= hdr_d;
    end
  end

  assign acc_s[0] = hdr_q;

  for (genvar d = 0; d < LIMIT; d++) begin : g_lane
    tsog_lane #(
      .LANE (d)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (en[0]),
      .func_i   (func_i),
      .shift_i  (shift[SEL_W-1:0]),
      .idx_i    (idx),
      .shape_i  (shape_q[d]),
      .active_i (3'(d) < rank_q),
      .res_o    (lanes_s[0][d])
    );
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_merge
    tsog_merge #(
      .NLANE (LIMIT),
      .STEP  (k - 1)
    ) u_merge (
      .clk_i   (clk_i),
      .en_i    (en[k]),
      .acc_i   (acc_s[k-1]),
      .lanes_i (lanes_s[k-1]),
      .acc_o   (acc_s[k]),
      .lanes_o (lanes_s[k])
    );
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign status_o    = acc_s[NSTG-1].status;
  assign offset_o    = (acc_s[NSTG-1].status == STATUS_OK) ? acc_s[NSTG-1].acc : '0;
  assign error_dim_o = (acc_s[NSTG-1].status == STATUS_RANGE ||
                        acc_s[NSTG-1].status == STATUS_OVERFLOW) ? acc_s[NSTG-1].edim : '0;

endmodule

// ----- tb/sv/tensor_strided_offset_generator_top_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the strided tensor offset generator top level
module tensor_strided_offset_generator_top_test;
  import tsog_pkg::*;

  localparam int MAX_RANK       = 4;
  localparam int RANK_LIMIT     = (MAX_RANK < CARRIED) ? MAX_RANK : CARRIED;
  localparam bit FUNC_DIRECT    = 1'b0;
  localparam bit FUNC_BCAST     = 1'b1;
  localparam logic [OFS_W-1:0]  OFS_MAX  = '1;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
  localparam int RANDOM_PHASES  = 30;
  localparam int PHASE_REQUESTS = 60;
  localparam int DRAIN_CYCLES   = 2 * (RANK_LIMIT + 1);
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [CARRIED-1:0][IDX_W-1:0] idx_vec_t;
  typedef logic [CARRIED-1:0][OFS_W-1:0] dim_vec_t;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [1:0]       status;
    logic [1:0]       edim;
  } offset_res_t;

  class offset_scoreboard;
    logic [2:0]       rank;
    logic [OFS_W-1:0] base;
    dim_vec_t         dims;
    offset_res_t      pending[$];
    int               errors;

    function new();
      rank   = '0;
      base   = '0;
      dims   = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] value);
      if (idx == REG_RANK) rank = value[2:0];
      else if (idx == REG_BASE) base = value;
      else dims[idx - REG_DIM0] = value;
    endfunction

    function offset_res_t predict_offset(bit mode, logic [2:0] count, idx_vec_t ix);
      offset_res_t             res;
      logic [63:0]             acc;
      logic [63:0]             term;
      logic [SIZE_W-1:0]       size;
      logic [SIZE_W-1:0]       stride;
      logic signed [IDX_W-1:0] v;
      int                      shift;
      res   = '0;
      acc   = {1'b0, base};
      shift = 0;
      if (rank > RANK_LIMIT || count > RANK_LIMIT) res.status = STATUS_RANK;
      else if (mode == FUNC_DIRECT && count != rank) res.status = STATUS_RANK;
      else if (mode == FUNC_BCAST && rank > count) res.status = STATUS_RANK;
      if (res.status == STATUS_OK && mode == FUNC_BCAST) shift = count - rank;
      for (int d = 0; d < int'(rank) && res.status == STATUS_OK; d++) begin
        size   = dims[d][SIZE_W-1:0];
        stride = dims[d][STRIDE_LSB +: SIZE_W];
        // broadcast dimensions of size one always take index zero
        v = (mode == FUNC_BCAST && size == 1) ? '0 : ix[(shift + d) % CARRIED];
        if (v < 0 || v >= $signed({1'b0, size})) begin
          res.status = STATUS_RANGE;
          res.edim   = 2'(d);
        end else begin
          term = 64'(v[IDX_W-2:0]) * 64'(stride);
          if (term > {1'b0, OFS_MAX} - acc) begin
            res.status = STATUS_OVERFLOW;
            res.edim   = 2'(d);
          end else begin
            acc += term;
          end
        end
      end
      if (res.status == STATUS_OK) res.offset = acc[OFS_W-1:0];
      return res;
    endfunction

    function void note_request(bit mode, logic [2:0] count, idx_vec_t ix);
      pending.push_back(predict_offset(mode, count, ix));
    endfunction

    function void check_offset(logic [OFS_W-1:0] offset, logic [1:0] status,
                               logic [1:0] edim);
      offset_res_t want;
      if (pending.size() == 0) begin
        $error("unrequested result: offset %0d status %0d error_dim %0d",
               offset, status, edim);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (offset !== want.offset) begin
        $error("offset mismatch: expected %0d, actual %0d", want.offset, offset);
        errors++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (edim !== want.edim) begin
        $error("error_dim mismatch: expected %0d, actual %0d", want.edim, edim);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i     = '0;
  logic [OFS_W-1:0]        cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic                    func_i        = 1'b0;
  logic [2:0]              index_count_i = '0;
  logic signed [IDX_W-1:0] idx_0_i       = '0;
  logic signed [IDX_W-1:0] idx_1_i       = '0;
  logic signed [IDX_W-1:0] idx_2_i       = '0;
  logic signed [IDX_W-1:0] idx_3_i       = '0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [OFS_W-1:0]        offset_o;
  logic [1:0]              status_o;
  logic [1:0]              error_dim_o;

  offset_scoreboard sb;
  bit               send_calm = 1'b0;
  int               idle_cycles = 0;

  tensor_strided_offset_generator_top #(.MAX_RANK(MAX_RANK)) dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_request(func_i, index_count_i, {idx_3_i, idx_2_i, idx_1_i, idx_0_i});
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_offset(offset_o, status_o, error_dim_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("tensor_strided_offset_generator_top_test failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    bit calm;
    calm = 1'b0;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      repeat (gap) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  function automatic idx_vec_t idx4(logic [IDX_W-1:0] i0, logic [IDX_W-1:0] i1,
                                    logic [IDX_W-1:0] i2, logic [IDX_W-1:0] i3);
    return {i3, i2, i1, i0};
  endfunction

  function automatic logic [OFS_W-1:0] dim_word(logic [SIZE_W-1:0] size,
                                                logic [SIZE_W-1:0] stride);
    return {stride, 1'b0, size};
  endfunction

  function automatic logic [IDX_W-1:0] any_index();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] index_for(logic [SIZE_W-1:0] size);
    int roll;
    roll = $urandom_range(0, 99);
    if (size == 0 || roll >= 94) return any_index();
    if (roll >= 88) return {1'b0, size};
    if (roll >= 80) return {1'b0, size} - 1;
    return $urandom_range(0, size - 1);
  endfunction

  task automatic send_request(bit mode, logic [2:0] count, idx_vec_t ix);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    func_i        = mode;
    index_count_i = count;
    idx_0_i       = ix[0];
    idx_1_i       = ix[1];
    idx_2_i       = ix[2];
    idx_3_i       = ix[3];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic random_request();
    bit         mode;
    logic [2:0] count;
    idx_vec_t   ix;
    int         shift;
    mode = 1'($urandom_range(0, 1));
    for (int k = 0; k < CARRIED; k++) ix[k] = any_index();
    // mostly well-formed requests, the rest arbitrary counts
    if ($urandom_range(0, 99) < 85 && sb.rank <= RANK_LIMIT) begin
      count = (mode == FUNC_DIRECT) ? sb.rank : 3'($urandom_range(sb.rank, RANK_LIMIT));
      shift = count - sb.rank;
      for (int d = 0; d < int'(sb.rank); d++)
        ix[shift + d] = index_for(sb.dims[d][SIZE_W-1:0]);
    end else begin
      count = 3'($urandom_range(0, 7));
    end
    send_request(mode, count, ix);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    sb.set_reg(idx, value);
  endtask

  task automatic load_settings(logic [2:0] rank, logic [OFS_W-1:0] base,
                               logic [OFS_W-1:0] d0, logic [OFS_W-1:0] d1,
                               logic [OFS_W-1:0] d2, logic [OFS_W-1:0] d3);
    write_reg(REG_RANK, OFS_W'(rank));
    write_reg(REG_BASE, base);
    write_reg(REG_DIM0, d0);
    write_reg(REG_DIM0 + 3'd1, d1);
    write_reg(REG_DIM0 + 3'd2, d2);
    write_reg(REG_DIM0 + 3'd3, d3);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic finish_phase();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0]        rank;
    logic [OFS_W-1:0]  base;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] stride;
    dim_vec_t          dims;
    int                roll;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // four dimensions, one of size one
    load_settings(3'd4, 63'd100, dim_word(3, 1), dim_word(1, 7), dim_word(5, 3),
                  dim_word(2, 60));
    send_request(FUNC_DIRECT, 3'd4, idx4(2, 0, 4, 1));
    send_request(FUNC_BCAST, 3'd4, idx4(2, 9, 4, 1));
    send_request(FUNC_DIRECT, 3'd3, idx4(0, 0, 0, 0));
    send_request(FUNC_BCAST, 3'd3, idx4(0, 0, 0, 0));
    send_request(FUNC_DIRECT, 3'd5, idx4(0, 0, 0, 0));
    send_request(FUNC_BCAST, 3'd7, idx4(0, 0, 0, 0));
    send_request(FUNC_DIRECT, 3'd4, idx4(32'h8000_0000, 0, 0, 0));
    send_request(FUNC_DIRECT, 3'd4, idx4(0, 0, 5, 0));
    send_request(FUNC_DIRECT, 3'd4, idx4(0, 0, 0, 32'h7fff_ffff));
    send_request(FUNC_DIRECT, 3'd4, idx4(0, 1, 0, 0));
    finish_phase();

    // right alignment of broadcast indices
    load_settings(3'd2, 63'd7, dim_word(4, 2), dim_word(3, 10), dim_word(6, 0),
                  dim_word(6, 0));
    send_request(FUNC_BCAST, 3'd4, idx4('1, '1, 3, 2));
    send_request(FUNC_BCAST, 3'd2, idx4(3, 2, 0, 0));
    finish_phase();

    // rank zero with the largest base
    load_settings(3'd0, OFS_MAX, '0, '0, '0, '0);
    send_request(FUNC_DIRECT, 3'd0, idx4('1, '1, '1, '1));
    send_request(FUNC_BCAST, 3'd4, idx4('1, '1, '1, '1));
    send_request(FUNC_DIRECT, 3'd1, idx4(0, 0, 0, 0));
    finish_phase();

    // rank register beyond the limit
    load_settings(3'd7, '0, dim_word(SIZE_MAX, 0), dim_word(SIZE_MAX, 0),
                  dim_word(SIZE_MAX, 0), dim_word(SIZE_MAX, 0));
    send_request(FUNC_DIRECT, 3'd7, idx4(0, 0, 0, 0));
    send_request(FUNC_BCAST, 3'd4, idx4(0, 0, 0, 0));
    finish_phase();

    // largest sizes and strides, overflow within the sum
    load_settings(3'd4, '0, OFS_MAX, OFS_MAX, OFS_MAX, OFS_MAX);
    send_request(FUNC_DIRECT, 3'd4, idx4(32'h7fff_fffe, 32'h7fff_fffe, 32'h7fff_fffe,
                                         32'h7fff_fffe));
    send_request(FUNC_DIRECT, 3'd4, idx4(0, 0, 0, 0));
    finish_phase();

    // sum landing exactly on the top, then an empty dimension
    load_settings(3'd3, OFS_MAX - 63'd5, dim_word(10, 3), dim_word(10, 1), dim_word(0, 1),
                  dim_word(0, 1));
    send_request(FUNC_DIRECT, 3'd3, idx4(1, 2, 0, 0));
    send_request(FUNC_DIRECT, 3'd3, idx4(2, 0, 0, 0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      finish_phase();
      roll = $urandom_range(0, 9);
      if (roll == 0) rank = 3'd0;
      else if (roll == 1) rank = 3'($urandom_range(RANK_LIMIT + 1, 7));
      else rank = 3'($urandom_range(1, RANK_LIMIT));
      case ($urandom_range(0, 5))
        0: base = '0;
        1: base = OFS_W'($urandom_range(0, 1000));
        2: base = OFS_MAX - OFS_W'($urandom_range(0, 1000));
        3: base = {2'b01, 61'($urandom())};
        default: base = OFS_W'({$urandom(), $urandom()});
      endcase
      for (int d = 0; d < CARRIED; d++) begin
        case ($urandom_range(0, 9))
          0: size = '0;
          1, 2: size = 1;
          3: size = SIZE_MAX;
          4: size = SIZE_W'($urandom());
          default: size = SIZE_W'($urandom_range(2, 8));
        endcase
        case ($urandom_range(0, 6))
          0: stride = '0;
          1: stride = SIZE_MAX;
          2: stride = SIZE_W'($urandom());
          default: stride = SIZE_W'($urandom_range(1, 100));
        endcase
        // the bit between size and stride is unused
        dims[d] = {stride, 1'($urandom_range(0, 1)), size};
      end
      load_settings(rank, base, dims[0], dims[1], dims[2], dims[3]);
      repeat (PHASE_REQUESTS) random_request();
    end

    finish_phase();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tensor_strided_offset_generator_top_test passed");
    else
      $display("tensor_strided_offset_generator_top_test failed");
    $finish;
  end

endmodule

// ----- tensor_strided_offset_generator_top.f -----
rtl/tsog_pkg.sv
rtl/tsog_lane.sv
rtl/tsog_merge.sv
rtl/tensor_strided_offset_generator_top.sv
tb/sv/tensor_strided_offset_generator_top_test.sv
